/* rtl/core/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// sfr_pkg
// Types, codes and helpers for the sync-header frame receiver with CRC-16.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 256;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED  = 1'b1;

    localparam logic [7:0]  SYNC_RESET = 8'h55;
    localparam logic [15:0] SEED_RESET = 16'h1D0F;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    localparam logic [15:0] TYPE_S1 = 16'h7331;
    localparam logic [15:0] TYPE_G1 = 16'h6731;
    localparam logic [15:0] TYPE_I1 = 16'h6931;

    localparam logic       KIND_PAYLOAD = 1'b0;
    localparam logic       KIND_STATUS  = 1'b1;

    localparam logic [1:0] CLASS_UNKNOWN = 2'd0;
    localparam logic [1:0] CLASS_S1      = 2'd1;
    localparam logic [1:0] CLASS_G1      = 2'd2;
    localparam logic [1:0] CLASS_I1      = 2'd3;

    localparam logic [1:0] STATUS_GOOD     = 2'd0;
    localparam logic [1:0] STATUS_BAD_CRC  = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [15:0] packet_type;
        logic [1:0]  type_class;
        logic [7:0]  payload_length;
        logic [1:0]  frame_status;
        logic        last;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [1:0] class_of(input logic [15:0] t);
        logic [1:0] cls;
        cls = CLASS_UNKNOWN;
        if (t == TYPE_S1)
        begin
            cls = CLASS_S1;
        end
        else if (t == TYPE_G1)
        begin
            cls = CLASS_G1;
        end
        else if (t == TYPE_I1)
        begin
            cls = CLASS_I1;
        end
        return cls;
    endfunction

endpackage

/* rtl/core/sfr_if.sv */
// ----------------------------------------------------------------------------
// sfr_if
// Channel interfaces: received bytes, results, configuration writes.
// ----------------------------------------------------------------------------
interface sfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_result_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [15:0] packet_type;
    logic [1:0]  type_class;
    logic [7:0]  payload_length;
    logic [1:0]  frame_status;
    logic        last;

    modport source (output valid, output result_kind, output payload_byte,
                    output payload_index, output packet_type, output type_class,
                    output payload_length, output frame_status, output last,
                    input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input payload_index, input packet_type, input type_class,
                    input payload_length, input frame_status, input last,
                    output ready);
endinterface

interface sfr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sfr_pkg::CFG_IDX_W-1:0] index;
    logic [15:0]                   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/sync_frame_receiver_crc16_unit.sv */
// ----------------------------------------------------------------------------
// sync_frame_receiver_crc16_unit
// Hunts for a two-byte sync header, parses type/length/payload/CRC and
// emits payload bytes and one end-of-frame status: CRC-16 check or too long.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  ---------+-----+------------------------------------------------------
//  rx       | in  | rx_byte
//  result   | out | result_kind, payload_byte/index, packet_type,
//           |     | type_class, payload_length, frame_status, last
//  cfg      | in  | index (0 sync_byte, 1 crc_seed), data
//
//  One byte per cycle while rx is ready; each item is parsed and its CRC-16
//  byte update done in the cycle it is accepted, the result lands in one
//  output register. rx is ready while that register is empty or being drained.
//  Reset returns to hunting; sync_byte 0x55, crc_seed 0x1D0F. cfg always ready.
// ----------------------------------------------------------------------------
module sync_frame_receiver_crc16_unit #(
    parameter int MAX_FRAME_BYTES = sfr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    sfr_byte_if.sink            rx,
    sfr_result_if.source        result,
    sfr_cfg_if.sink             cfg
);

    localparam logic [9:0] MaxBytes = 10'(MAX_FRAME_BYTES);

    logic [7:0]  sync_reg;
    logic [15:0] seed_reg;

    logic        in_frame_reg, in_frame_next;
    logic [7:0]  prev_reg, prev_next;
    logic        prev_valid_reg, prev_valid_next;
    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] type_reg, type_next;
    logic [7:0]  crc_hi_reg, crc_hi_next;

    sfr_pkg::result_t res_reg, res_next;
    logic             res_valid_reg, res_valid_next;
    logic             load;

    logic        rx_fire;
    logic [7:0]  b;
    logic [15:0] crc_upd;
    logic [8:0]  pay_end;
    logic [8:0]  pay_idx;

    assign rx.ready  = !res_valid_reg || result.ready;
    assign rx_fire   = rx.valid && rx.ready;
    assign b         = rx.rx_byte;
    assign crc_upd   = sfr_pkg::crc_byte(crc_reg, b);
    assign pay_end   = {1'b0, len_reg} + 9'd3;
    assign pay_idx   = pos_reg - 9'd3;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        crc_next        = crc_reg;
        type_next       = type_reg;
        crc_hi_next     = crc_hi_reg;
        load            = 1'b0;

        res_next.result_kind    = sfr_pkg::KIND_PAYLOAD;
        res_next.payload_byte   = '0;
        res_next.payload_index  = '0;
        res_next.packet_type    = type_reg;
        res_next.type_class     = sfr_pkg::class_of(type_reg);
        res_next.payload_length = len_reg;
        res_next.frame_status   = sfr_pkg::STATUS_GOOD;
        res_next.last           = 1'b0;

        if (rx_fire)
        begin
            if (!in_frame_reg)
            begin
                if (prev_valid_reg && prev_reg == sync_reg && b == sync_reg)
                begin
                    in_frame_next   = 1'b1;
                    prev_valid_next = 1'b0;
                    pos_next        = '0;
                    crc_next        = seed_reg;
                    type_next       = '0;
                    len_next        = '0;
                    crc_hi_next     = '0;
                end
                else
                begin
                    prev_next       = b;
                    prev_valid_next = 1'b1;
                end
            end
            else
            begin
                pos_next = pos_reg + 9'd1;
                if (pos_reg < 9'd2)
                begin
                    type_next = {type_reg[7:0], b};
                    crc_next  = crc_upd;
                end
                else if (pos_reg == 9'd2)
                begin
                    len_next = b;
                    crc_next = crc_upd;
                    if (({2'b00, b} + 10'd7) > MaxBytes)
                    begin
                        in_frame_next           = 1'b0;
                        load                    = 1'b1;
                        res_next.result_kind    = sfr_pkg::KIND_STATUS;
                        res_next.last           = 1'b1;
                        res_next.payload_length = b;
                        res_next.frame_status   = sfr_pkg::STATUS_TOO_LONG;
                    end
                end
                else if (pos_reg < pay_end)
                begin
                    crc_next               = crc_upd;
                    load                   = 1'b1;
                    res_next.payload_byte  = b;
                    res_next.payload_index = pay_idx[7:0];
                end
                else if (pos_reg == pay_end)
                begin
                    crc_hi_next = b;
                end
                else
                begin
                    in_frame_next         = 1'b0;
                    load                  = 1'b1;
                    res_next.result_kind  = sfr_pkg::KIND_STATUS;
                    res_next.last         = 1'b1;
                    res_next.frame_status = ({crc_hi_reg, b} == crc_reg)
                                          ? sfr_pkg::STATUS_GOOD
                                          : sfr_pkg::STATUS_BAD_CRC;
                end
            end
        end

        res_valid_next = load || (res_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg       <= sfr_pkg::SYNC_RESET;
            seed_reg       <= sfr_pkg::SEED_RESET;
            in_frame_reg   <= 1'b0;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
            pos_reg        <= '0;
            len_reg        <= '0;
            crc_reg        <= sfr_pkg::SEED_RESET;
            type_reg       <= '0;
            crc_hi_reg     <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    sfr_pkg::CFG_SYNC_BYTE: sync_reg <= cfg.data[7:0];
                    sfr_pkg::CFG_CRC_SEED:  seed_reg <= cfg.data;
                    default: ;
                endcase
            end
            in_frame_reg   <= in_frame_next;
            prev_reg       <= prev_next;
            prev_valid_reg <= prev_valid_next;
            pos_reg        <= pos_next;
            len_reg        <= len_next;
            crc_reg        <= crc_next;
            type_reg       <= type_next;
            crc_hi_reg     <= crc_hi_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.result_kind    = res_reg.result_kind;
    assign result.payload_byte   = res_reg.payload_byte;
    assign result.payload_index  = res_reg.payload_index;
    assign result.packet_type    = res_reg.packet_type;
    assign result.type_class     = res_reg.type_class;
    assign result.payload_length = res_reg.payload_length;
    assign result.frame_status   = res_reg.frame_status;
    assign result.last           = res_reg.last;

    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.last == result.result_kind)
        else $error("last differs from result kind");

    a_status_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.result_kind == sfr_pkg::KIND_STATUS
        |-> result.payload_byte == 8'd0 && result.payload_index == 8'd0)
        else $error("status result carries payload data");

    a_header_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_frame_reg) |-> !prev_valid_reg)
        else $error("header found without clearing previous byte");

    a_status_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        load && res_next.result_kind == sfr_pkg::KIND_STATUS |=> !in_frame_reg)
        else $error("frame still open after status");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg && pos_reg > 9'd3 |-> pos_reg <= pay_end + 9'd1)
        else $error("frame position past CRC");

endmodule
